/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also checks during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lmph_pkg.sv */
// Types and constants for the peak-hold level meter.
// Used by level_meter_peak_hold and its checker; depends on nothing.
package lmph_pkg;

    localparam int PART_W  = 4;
    localparam int VEL_W   = 7;
    localparam int LEVEL_W = 15;
    localparam int HOLD_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Full scale: velocity 127 shifted up by 8
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd32512;

    localparam logic [LEVEL_W-1:0] BAR_FALLOFF_RST  = 15'd1024;
    localparam logic [LEVEL_W-1:0] PEAK_FALLOFF_RST = 15'd256;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST   = 8'd100;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAR_FALLOFF  = 2'd0,
        CFG_PEAK_FALLOFF = 2'd1,
        CFG_HOLD_TICKS   = 2'd2
    } cfg_reg_t;

    // Stored meter state of one part
    typedef struct packed {
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
        logic [HOLD_W-1:0]  hold;
    } meter_t;

endpackage

/* rtl/level_meter_peak_hold.sv */
// Per-part bar meter with peak hold and falloff.
// Depends on lmph_pkg.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_part_index, s_part_active, s_velocity
// m_        out  m_valid/m_ready    m_part_out, m_bar_level, m_peak_level
// cfg_      in   cfg_we             cfg_index, cfg_data
//
// One item per cycle sustained while m_ready is high; the input register loads at the
// input transfer, and the result register, which drives m_valid, loads from it when
// the result slot is free. Meter state is updated at the same edge the result register
// loads, so an item for the same part in the next cycle sees the new state.
// Synchronous active-low reset clears all meters and loads register defaults.
// A stalled result holds; the input register takes one more item and then holds it.
module level_meter_peak_hold #(
    parameter int NUM_PARTS = 9
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lmph_pkg::PART_W-1:0]       s_part_index,
    input  logic                              s_part_active,
    input  logic [lmph_pkg::VEL_W-1:0]        s_velocity,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lmph_pkg::PART_W-1:0]       m_part_out,
    output logic [lmph_pkg::LEVEL_W-1:0]      m_bar_level,
    output logic [lmph_pkg::LEVEL_W-1:0]      m_peak_level,
    input  logic                              cfg_we,
    input  logic [lmph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmph_pkg::LEVEL_W-1:0]      cfg_data
);

    localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int EXT_W = 6;

    // Configuration registers
    logic [lmph_pkg::LEVEL_W-1:0] bar_falloff_reg;
    logic [lmph_pkg::LEVEL_W-1:0] peak_falloff_reg;
    logic [lmph_pkg::HOLD_W-1:0]  hold_ticks_reg;

    // Input register
    logic                         in_valid_reg, in_valid_next;
    logic [lmph_pkg::PART_W-1:0]  in_part_reg;
    logic                         in_active_reg;
    logic [lmph_pkg::VEL_W-1:0]   in_vel_reg;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic [lmph_pkg::PART_W-1:0]  out_part_reg;
    logic [lmph_pkg::LEVEL_W-1:0] out_bar_reg;
    logic [lmph_pkg::LEVEL_W-1:0] out_peak_reg;

    // Meter state
    lmph_pkg::meter_t             meter_reg [NUM_PARTS];
    lmph_pkg::meter_t             meter_cur;
    lmph_pkg::meter_t             meter_next;

    logic                         advance;
    logic                         in_range;
    logic [EXT_W-1:0]             part_ext;
    logic [IDX_W-1:0]             idx;

    logic [lmph_pkg::LEVEL_W-1:0] scaled;
    logic [lmph_pkg::LEVEL_W-1:0] bar_up;
    logic [lmph_pkg::LEVEL_W-1:0] bar_down;
    logic [lmph_pkg::LEVEL_W-1:0] bar_new;
    logic                         take_peak;
    logic [lmph_pkg::LEVEL_W-1:0] peak_mid;
    logic [lmph_pkg::HOLD_W-1:0]  hold_mid;
    logic [lmph_pkg::LEVEL_W-1:0] peak_new;
    logic [lmph_pkg::HOLD_W-1:0]  hold_new;

    // Handshake: move the input item on when the result slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) ? 1'b1 :
                            (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Decode part and fetch its meter
    assign part_ext  = EXT_W'(in_part_reg);
    assign idx       = part_ext[IDX_W-1:0];
    assign in_range  = 32'(in_part_reg) < NUM_PARTS;
    assign meter_cur = meter_reg[idx];

    // Bar stage: rise to the new level, or fall off when inactive
    always_comb begin
        scaled   = {in_vel_reg, 8'd0};
        bar_up   = (scaled >= meter_cur.bar) ? scaled : meter_cur.bar;
        bar_down = (meter_cur.bar > bar_falloff_reg) ?
                   (meter_cur.bar - bar_falloff_reg) : '0;
        bar_new  = in_active_reg ? bar_up : bar_down;
    end

    // Peak stage: take a new peak, then either fall off or count the hold down
    always_comb begin
        take_peak = bar_new >= meter_cur.peak;
        peak_mid  = take_peak ? bar_new : meter_cur.peak;
        hold_mid  = take_peak ? hold_ticks_reg : meter_cur.hold;
        if (hold_mid == '0 && peak_mid != '0) begin
            peak_new = (peak_mid > peak_falloff_reg) ? (peak_mid - peak_falloff_reg) : '0;
            hold_new = hold_mid;
        end else begin
            peak_new = peak_mid;
            hold_new = (hold_mid != '0) ? (hold_mid - 8'd1) : '0;
        end
        meter_next.bar  = bar_new;
        meter_next.peak = peak_new;
        meter_next.hold = hold_new;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_falloff_reg  <= lmph_pkg::BAR_FALLOFF_RST;
            peak_falloff_reg <= lmph_pkg::PEAK_FALLOFF_RST;
            hold_ticks_reg   <= lmph_pkg::HOLD_TICKS_RST;
        end else if (cfg_we) begin
            case (lmph_pkg::cfg_reg_t'(cfg_index))
                lmph_pkg::CFG_BAR_FALLOFF:  bar_falloff_reg  <= cfg_data;
                lmph_pkg::CFG_PEAK_FALLOFF: peak_falloff_reg <= cfg_data;
                lmph_pkg::CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data[lmph_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_part_reg   <= s_part_index;
            in_active_reg <= s_part_active;
            in_vel_reg    <= s_velocity;
        end
    end

    // Load the result; out-of-range parts report zero levels
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_part_reg <= in_part_reg;
            out_bar_reg  <= in_range ? meter_next.bar  : '0;
            out_peak_reg <= in_range ? meter_next.peak : '0;
        end
    end

    // Write back the meter of the updated part
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PARTS; i++) begin
                meter_reg[i] <= '0;
            end
        end else if (advance && in_range) begin
            meter_reg[idx] <= meter_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_part_out   = out_part_reg;
    assign m_bar_level  = out_bar_reg;
    assign m_peak_level = out_peak_reg;

endmodule

/* rtl/lmph_checker.sv */
// Port-level checks for level_meter_peak_hold, bound to the top level.
// Depends on lmph_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lmph_checker #(
    parameter int NUM_PARTS = 9
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [lmph_pkg::PART_W-1:0]       s_part_index,
    input logic                              s_part_active,
    input logic [lmph_pkg::VEL_W-1:0]        s_velocity,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [lmph_pkg::PART_W-1:0]       m_part_out,
    input logic [lmph_pkg::LEVEL_W-1:0]      m_bar_level,
    input logic [lmph_pkg::LEVEL_W-1:0]      m_peak_level,
    input logic                              cfg_we,
    input logic [lmph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [lmph_pkg::LEVEL_W-1:0]      cfg_data
);

    // Reset empties the result slot
    `ASSERT_CLK_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds its payload
    `ASSERT_CLK(a_stall_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_part_out) && $stable(m_bar_level) && $stable(m_peak_level)), "stalled result changed")

    // Parts beyond the meter bank report zero levels
    `ASSERT_CLK(a_range_zero, aclk, aresetn, (m_valid && (32'(m_part_out) >= NUM_PARTS)) |-> (m_bar_level == '0 && m_peak_level == '0), "out-of-range part has nonzero level")

    // Levels never exceed full scale
    `ASSERT_CLK(a_full_scale, aclk, aresetn, m_valid |-> (m_bar_level <= lmph_pkg::LEVEL_MAX && m_peak_level <= lmph_pkg::LEVEL_MAX), "level above full scale")

endmodule

bind level_meter_peak_hold lmph_checker #(.NUM_PARTS(NUM_PARTS)) u_lmph_checker (.*);
